[rtl/obgv_pkg.sv]
// obgv_pkg: shared types and constants for the oriented bit grid view
// action codes, controller state, controller/datapath command and status words
// no dependencies
package obgv_pkg;

    localparam int COORD_W     = 6;
    localparam int GRID_W      = 7;
    localparam int ADDR_CALC_W = 2 * GRID_W;

    localparam logic [GRID_W-1:0] GRID_SIZE_RESET = 7'd64;

    localparam logic [1:0] ACT_TOGGLE = 2'd0;
    localparam logic [1:0] ACT_ROTATE = 2'd1;
    localparam logic [1:0] ACT_FLIP   = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_FETCH  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_done;
        logic mem_op;
    } t_ctrl_sts;

endpackage

[rtl/obgv_ram.sv]
// obgv_ram: generic single-port ram with registered read data
// no dependencies
module obgv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/obgv_datapath.sv]
// obgv_datapath: orientation state, view-to-storage address map, cell ram and result register
// depends on obgv_pkg and obgv_ram
module obgv_datapath #(
    parameter int MAX_SIDE = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  obgv_pkg::t_ctrl_cmd             i_cmd,
    output obgv_pkg::t_ctrl_sts             o_sts,
    input  logic [1:0]                      i_action,
    input  logic [obgv_pkg::COORD_W-1:0]    i_row,
    input  logic [obgv_pkg::COORD_W-1:0]    i_col,
    input  logic                            i_direction,
    input  logic                            i_cfg_we,
    input  logic [obgv_pkg::GRID_W-1:0]     i_cfg_wdata,
    output logic                            o_strobe,
    output logic                            o_cell_bit
);

    localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int AW      = $clog2(DEPTH);
    localparam int CAP     = (MAX_SIDE > 127) ? 127 : MAX_SIDE;
    localparam int GW      = obgv_pkg::GRID_W;
    localparam int CW      = obgv_pkg::ADDR_CALC_W;
    localparam logic [GW-1:0] SIDE_CAP = GW'(CAP);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    logic [GW-1:0] r_grid;
    logic [1:0]    r_quarter, n_quarter;
    logic          r_transposed, n_transposed;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_is_read;
    logic          r_inside, n_inside;
    logic          r_strobe;
    logic          r_cell_bit;

    logic [GW-1:0] side, side_m1, r7, c7, mr, mc, map_r, map_c;
    logic [CW-1:0] prod, sum;
    logic          ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_addr;

    // side in use and view coordinate remap
    always_comb begin
        side    = (r_grid > SIDE_CAP) ? SIDE_CAP : r_grid;
        side_m1 = side - 7'd1;
        r7      = {1'b0, i_row};
        c7      = {1'b0, i_col};
        case (r_quarter)
            2'd0: begin
                mr = r7;
                mc = c7;
            end
            2'd1: begin
                mr = c7;
                mc = side_m1 - r7;
            end
            2'd2: begin
                mr = side_m1 - r7;
                mc = side_m1 - c7;
            end
            2'd3: begin
                mr = side_m1 - c7;
                mc = r7;
            end
            default: begin
                mr = r7;
                mc = c7;
            end
        endcase
        map_r    = r_transposed ? mc : mr;
        map_c    = r_transposed ? mr : mc;
        prod     = {{(CW-GW){1'b0}}, map_r} * {{(CW-GW){1'b0}}, side};
        sum      = prod + {{(CW-GW){1'b0}}, map_c};
        n_inside = (r7 < side) && (c7 < side);
        n_addr   = n_inside ? AW'(sum) : '0;
    end

    // orientation update
    always_comb begin
        n_quarter    = r_quarter;
        n_transposed = r_transposed;
        case (i_action)
            obgv_pkg::ACT_ROTATE: begin
                n_quarter = r_quarter + (i_direction ? 2'd1 : 2'd3);
            end
            obgv_pkg::ACT_FLIP: begin
                n_transposed = ~r_transposed;
                n_quarter    = (2'd0 - r_quarter) + (i_direction ? 2'd3 : 2'd1);
            end
            default: begin
                n_quarter    = r_quarter;
                n_transposed = r_transposed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid       <= obgv_pkg::GRID_SIZE_RESET;
            r_quarter    <= 2'd0;
            r_transposed <= 1'b0;
            r_clr_addr   <= '0;
            r_strobe     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_grid <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_quarter    <= n_quarter;
                r_transposed <= n_transposed;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_strobe <= i_cmd.finish && r_is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr    <= n_addr;
            r_inside  <= n_inside;
            r_is_read <= (i_action == obgv_pkg::ACT_READ);
        end
        if (i_cmd.finish) begin
            r_cell_bit <= ram_rdata & r_inside;
        end
    end

    // clear sweep, then toggle write-back
    assign ram_addr  = i_cmd.clear ? r_clr_addr : r_addr;
    assign ram_we    = i_cmd.clear || (i_cmd.finish && !r_is_read && r_inside);
    assign ram_wdata = i_cmd.clear ? 1'b0 : ~ram_rdata;

    obgv_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_sts.clear_done = (r_clr_addr == CLR_LAST);
    assign o_sts.mem_op     = (i_action == obgv_pkg::ACT_TOGGLE) ||
                              (i_action == obgv_pkg::ACT_READ);
    assign o_strobe         = r_strobe;
    assign o_cell_bit       = r_cell_bit;

endmodule

[rtl/obgv_ctrl.sv]
// obgv_ctrl: controller state machine for clear sweep and cell read-modify-write
// depends on obgv_pkg
module obgv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  obgv_pkg::t_ctrl_sts i_sts,
    output obgv_pkg::t_ctrl_cmd o_cmd,
    output logic                busy
);

    obgv_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            obgv_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = obgv_pkg::ST_IDLE;
                end
            end
            obgv_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.mem_op) begin
                        n_state = obgv_pkg::ST_FETCH;
                    end
                end
            end
            obgv_pkg::ST_FETCH: begin
                n_state = obgv_pkg::ST_FINISH;
            end
            obgv_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = obgv_pkg::ST_IDLE;
            end
            default: begin
                n_state = obgv_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= obgv_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != obgv_pkg::ST_IDLE);

endmodule

[rtl/oriented_bit_grid_view.sv]
// oriented_bit_grid_view: top level, square bit grid seen through a lazy rotate/transpose view
// depends on obgv_pkg, obgv_ctrl, obgv_datapath (and obgv_ram below it)
//
//  channel   signals                                         handshake
//  -------   ----------------------------------------------  ------------------------
//  command   i_action, i_row, i_col, i_direction             start && !busy
//  result    o_cell_bit                                      o_strobe, one cycle
//  config    i_cfg_wdata (grid_size)                         i_cfg_we
//
// rotate and flip stay in idle; toggle and read pass through fetch and finish,
// set by the single-port cell ram (registered read, then write-back or result
// register). a read word reaches o_strobe through the address register, the ram
// read register and the strobe register. after reset the ram is swept to zero,
// one cell a cycle, all MAX_SIDE*MAX_SIDE cells (4096 at the default), busy high;
// config writes are still taken. the receiver cannot stall; results are never held.
module oriented_bit_grid_view #(
    parameter int MAX_SIDE = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_action,
    input  logic [obgv_pkg::COORD_W-1:0]    i_row,
    input  logic [obgv_pkg::COORD_W-1:0]    i_col,
    input  logic                            i_direction,
    input  logic                            i_cfg_we,
    input  logic [obgv_pkg::GRID_W-1:0]     i_cfg_wdata,
    output logic                            o_strobe,
    output logic                            o_cell_bit
);

    obgv_pkg::t_ctrl_cmd cmd;
    obgv_pkg::t_ctrl_sts sts;

    obgv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    obgv_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (i_action),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_direction (i_direction),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_cell_bit  (o_cell_bit)
    );

endmodule

[rtl/obgv_checker.sv]
// obgv_checker: port-level assertions for oriented_bit_grid_view, bound to the top level
// depends on obgv_pkg
module obgv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_action,
    input logic       o_strobe
);

    // reset always starts the clear sweep
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low after reset");

    // every read command taken gives a read word on o_strobe
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == obgv_pkg::ACT_READ) |-> ##3 o_strobe)
        else $error("read word missing");

    // other commands give no word where a read word would appear
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action != obgv_pkg::ACT_READ) |-> ##3 !o_strobe)
        else $error("unexpected word");

    // a word always follows a busy cycle and never repeats
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) && !$past(o_strobe)))
        else $error("stray word");

endmodule

bind oriented_bit_grid_view obgv_checker u_obgv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_action (i_action),
    .o_strobe (o_strobe)
);
